// ===== hw/rtl/ppsb_pkg.sv =====
// Shared types and constants for the ping-pong sample buffer.
`timescale 1ns / 1ps
`default_nettype none

package ppsb_pkg;

  // Default geometry of the two banks
  localparam int BANK_DEPTH_DEF = 256;
  localparam int WORD_BITS_DEF  = 64;

  // Field widths fixed by the interface
  localparam int DATA_W      = 64;
  localparam int LIMIT_W     = 9;
  localparam int OUT_COUNT_W = 10;

  // Reset value of the push limit register
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 9'd256;

  // Depth of the queue between front and back
  localparam int QDEPTH = 2;

  // Operation codes carried in the mode field
  localparam logic [1:0] MODE_PUSH = 2'd0;
  localparam logic [1:0] MODE_POP  = 2'd1;
  localparam logic [1:0] MODE_SWAP = 2'd2;

  // Memory action the back end performs for one transaction
  typedef enum logic [1:0] {
    MEM_NONE,
    MEM_WRITE,
    MEM_READ
  } ppsb_mem_op_t;

  typedef struct packed {
    logic [1:0]        mode;
    logic [DATA_W-1:0] data_value;
  } in_item_t;

  typedef struct packed {
    logic                   ok;
    logic [DATA_W-1:0]      popped_value;
    logic [OUT_COUNT_W-1:0] total_count;
    logic                   is_empty;
  } out_item_t;

  // Result fields decided by the front end
  typedef struct packed {
    ppsb_mem_op_t           mem_op;
    logic                   ok;
    logic [OUT_COUNT_W-1:0] total_count;
    logic                   is_empty;
  } ppsb_ctrl_t;

  // Queue occupancy flags
  typedef struct packed {
    logic full;
    logic empty;
  } ppsb_q_status_t;

endpackage

`default_nettype wire

// ===== hw/rtl/ppsb_queue.sv =====
// Short FIFO that decouples the front end from the back end.
`timescale 1ns / 1ps
`default_nettype none

module ppsb_queue #(
  parameter int W     = 8,
  parameter int DEPTH = ppsb_pkg::QDEPTH
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    push,
  input  wire logic [W-1:0]            wdata,
  input  wire logic                    pop,
  output logic [W-1:0]                 rdata,
  output ppsb_pkg::ppsb_q_status_t     status
);
  import ppsb_pkg::*;

  localparam int PW  = $clog2(DEPTH);
  localparam int CNW = $clog2(DEPTH + 1);

  logic [W-1:0]   slot_r [DEPTH];
  logic [PW-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CNW-1:0] fill_r, fill_nxt;

  // Report occupancy
  always_comb begin
    status.full  = (fill_r == CNW'(DEPTH));
    status.empty = (fill_r == '0);
  end

  assign rdata = slot_r[rd_ptr_r];

  // Advance pointers with wrap at the queue depth
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    fill_nxt   = fill_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      fill_nxt = fill_r + 1'b1;
    end else if (pop && !push) begin
      fill_nxt = fill_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  // Store the incoming transaction
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= wdata;
    end
  end

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    status.full |-> !push)
    else $error("queue written while full");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    status.empty |-> !pop)
    else $error("queue read while empty");

  a_fill_tracks: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> fill_r == $past(fill_r) + 1'b1)
    else $error("queue fill count did not advance on push");

endmodule

`default_nettype wire

// ===== hw/rtl/ppsb_front.sv =====
// Front end: takes transactions, keeps bank heads and counts, decides each result.
`timescale 1ns / 1ps
`default_nettype none

module ppsb_front #(
  parameter int BANK_DEPTH = ppsb_pkg::BANK_DEPTH_DEF,
  parameter int WORD_BITS  = ppsb_pkg::WORD_BITS_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_valid,
  input  wire ppsb_pkg::in_item_t                in_item,
  output logic                                   in_stall,
  input  wire logic                              cfg_valid,
  input  wire logic [ppsb_pkg::LIMIT_W-1:0]      cfg_data,
  output logic                                   cfg_ready,
  input  wire ppsb_pkg::ppsb_q_status_t          q_status,
  output logic                                   q_push,
  output logic [$bits(ppsb_pkg::ppsb_ctrl_t) + $clog2(BANK_DEPTH) + WORD_BITS:0] q_wdata
);
  import ppsb_pkg::*;

  localparam int AW  = $clog2(BANK_DEPTH);
  localparam int CW  = $clog2(BANK_DEPTH + 1);
  localparam int SW  = CW + 1;
  localparam int TW  = CW + 1;
  localparam int LW  = (CW > LIMIT_W) ? CW : LIMIT_W;

  logic [AW-1:0]      head_r [2];
  logic [AW-1:0]      head_nxt [2];
  logic [CW-1:0]      count_r [2];
  logic [CW-1:0]      count_nxt [2];
  logic               wsel_r, wsel_nxt;
  logic [LIMIT_W-1:0] limit_r;

  logic          accept;
  logic          wb, rb, pop_bank;
  logic [LW-1:0] lim_ext, eff_lim;
  logic          push_ok, rd_have, wr_have, pop_ok;
  logic [SW-1:0] tail_sum;
  logic [AW-1:0] wslot, pslot, hnext;
  logic [AW:0]   hinc;
  logic [TW-1:0] total;
  ppsb_mem_op_t  mem_op;
  logic          ok;
  logic [AW:0]   addr;
  ppsb_ctrl_t    ctrl;

  assign accept    = in_valid && !q_status.full;
  assign in_stall  = q_status.full;
  assign q_push    = accept;
  assign cfg_ready = 1'b1;

  // Classify against current bank state
  always_comb begin
    wb      = wsel_r;
    rb      = ~wsel_r;
    lim_ext = LW'(limit_r);
    eff_lim = (lim_ext < LW'(BANK_DEPTH)) ? lim_ext : LW'(BANK_DEPTH);
    push_ok = LW'(count_r[wb]) < eff_lim;
    rd_have = count_r[rb] != '0;
    wr_have = count_r[wb] != '0;
    pop_ok  = rd_have || wr_have;
    // an empty read bank pops from the other one after an automatic swap
    pop_bank = rd_have ? rb : wb;

    // tail slot of the write bank, wrapped at the bank depth
    tail_sum = SW'(head_r[wb]) + SW'(count_r[wb]);
    wslot    = (tail_sum >= SW'(BANK_DEPTH)) ? AW'(tail_sum - SW'(BANK_DEPTH))
                                             : AW'(tail_sum);

    pslot = head_r[pop_bank];
    hinc  = {1'b0, pslot} + 1'b1;
    hnext = (hinc == (AW + 1)'(BANK_DEPTH)) ? '0 : AW'(hinc);
  end

  // Decide the operation and next bank state
  always_comb begin
    head_nxt[0]  = head_r[0];
    head_nxt[1]  = head_r[1];
    count_nxt[0] = count_r[0];
    count_nxt[1] = count_r[1];
    wsel_nxt     = wsel_r;
    ok           = 1'b0;
    mem_op       = MEM_NONE;
    addr         = '0;
    if (accept) begin
      unique case (in_item.mode)
        MODE_PUSH: begin
          if (push_ok) begin
            count_nxt[wb] = count_r[wb] + 1'b1;
            ok            = 1'b1;
            mem_op        = MEM_WRITE;
            addr          = {wb, wslot};
          end
        end
        MODE_POP: begin
          if (pop_ok) begin
            if (!rd_have) begin
              wsel_nxt = ~wsel_r;
            end
            head_nxt[pop_bank]  = hnext;
            count_nxt[pop_bank] = count_r[pop_bank] - 1'b1;
            ok                  = 1'b1;
            mem_op              = MEM_READ;
            addr                = {pop_bank, pslot};
          end
        end
        MODE_SWAP: begin
          if (wr_have) begin
            wsel_nxt = ~wsel_r;
            ok       = 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Pack the transaction for the back end
  always_comb begin
    total            = TW'(count_nxt[0]) + TW'(count_nxt[1]);
    ctrl.mem_op      = mem_op;
    ctrl.ok          = ok;
    ctrl.total_count = OUT_COUNT_W'(total);
    ctrl.is_empty    = (total == '0);
    q_wdata          = {ctrl, addr, in_item.data_value[WORD_BITS-1:0]};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r[0]  <= '0;
      head_r[1]  <= '0;
      count_r[0] <= '0;
      count_r[1] <= '0;
      wsel_r     <= 1'b0;
    end else begin
      head_r[0]  <= head_nxt[0];
      head_r[1]  <= head_nxt[1];
      count_r[0] <= count_nxt[0];
      count_r[1] <= count_nxt[1];
      wsel_r     <= wsel_nxt;
    end
  end

  // Hold the push limit
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= LIMIT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      limit_r <= cfg_data;
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r[0] <= CW'(BANK_DEPTH)) && (count_r[1] <= CW'(BANK_DEPTH)))
    else $error("bank count above bank depth");

  a_head_range: assert property (@(posedge clk) disable iff (!rst_n)
    (AW'(head_r[0]) <= AW'(BANK_DEPTH - 1)) && (AW'(head_r[1]) <= AW'(BANK_DEPTH - 1)))
    else $error("bank head out of range");

  a_swap_flips: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_item.mode == MODE_SWAP && wr_have) |=> wsel_r != $past(wsel_r))
    else $error("swap did not exchange banks");

endmodule

`default_nettype wire

// ===== hw/rtl/ppsb_back.sv =====
// Back end: performs bank memory access and holds the result for the consumer.
`timescale 1ns / 1ps
`default_nettype none

module ppsb_back #(
  parameter int BANK_DEPTH = ppsb_pkg::BANK_DEPTH_DEF,
  parameter int WORD_BITS  = ppsb_pkg::WORD_BITS_DEF
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire ppsb_pkg::ppsb_q_status_t q_status,
  input  wire logic [$bits(ppsb_pkg::ppsb_ctrl_t) + $clog2(BANK_DEPTH) + WORD_BITS:0] q_rdata,
  output logic                          q_pop,
  output logic                          out_valid,
  input  wire logic                     out_stall,
  output ppsb_pkg::out_item_t           out_item
);
  import ppsb_pkg::*;

  localparam int MAW = $clog2(BANK_DEPTH) + 1;
  localparam int CTW = $bits(ppsb_ctrl_t);

  logic [WORD_BITS-1:0] mem [2**MAW];

  logic                   take;
  ppsb_ctrl_t             ctrl;
  logic [MAW-1:0]         addr;
  logic [WORD_BITS-1:0]   word;

  logic                   out_valid_r;
  logic                   ok_r;
  logic                   read_r;
  logic [WORD_BITS-1:0]   rd_r;
  logic [OUT_COUNT_W-1:0] total_r;
  logic                   empty_r;

  // Unpack the queued transaction
  always_comb begin
    ctrl = ppsb_ctrl_t'(q_rdata[MAW + WORD_BITS +: CTW]);
    addr = q_rdata[WORD_BITS +: MAW];
    word = q_rdata[WORD_BITS-1:0];
  end

  // Advance when the output register is free or being drained
  assign take  = !q_status.empty && (!out_valid_r || !out_stall);
  assign q_pop = take;

  // Bank memory: at most one write or one registered read per transaction
  always_ff @(posedge clk) begin
    if (take && ctrl.mem_op == MEM_WRITE) begin
      mem[addr] <= word;
    end
    if (take && ctrl.mem_op == MEM_READ) begin
      rd_r <= mem[addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (take) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  // Capture result fields alongside the memory read
  always_ff @(posedge clk) begin
    if (take) begin
      ok_r    <= ctrl.ok;
      read_r  <= (ctrl.mem_op == MEM_READ);
      total_r <= ctrl.total_count;
      empty_r <= ctrl.is_empty;
    end
  end

  always_comb begin
    out_valid             = out_valid_r;
    out_item.ok           = ok_r;
    out_item.popped_value = read_r ? DATA_W'(rd_r) : '0;
    out_item.total_count  = total_r;
    out_item.is_empty     = empty_r;
  end

  a_read_is_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (take && ctrl.mem_op != MEM_NONE) |-> ctrl.ok)
    else $error("memory access for a refused transaction");

  a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
    take |-> (ctrl.is_empty == (ctrl.total_count == '0)))
    else $error("empty flag disagrees with total count");

  a_take_shows: assert property (@(posedge clk) disable iff (!rst_n)
    take |=> out_valid_r)
    else $error("taken transaction not presented");

endmodule

`default_nettype wire

// ===== hw/rtl/ping_pong_sample_buffer.sv =====
// Top level of the ping-pong sample buffer: front end, queue and back end.
//
//  channel | ports                          | direction | moves
//  --------+--------------------------------+-----------+-------------------------------
//  in      | in_valid, in_stall, in_item    | input     | one push, pop or swap request
//  out     | out_valid, out_stall, out_item | output    | one result per transaction
//  cfg     | cfg_valid, cfg_ready, cfg_data | input     | push limit (9 bits)
//
// One transaction per cycle sustained while out_stall stays low. A taken transaction enters
// the two-entry queue; the back end takes it from the queue once the result register is free
// or being drained, and the bank memory read and the result register load together, after
// which out_valid rises. rst_n is synchronous; it clears heads, counts and bank select and
// sets the limit to 256, never the bank memory, so no clearing pass is needed. A stalled
// result backs up the queue, and in_stall rises once both queue entries are held.
`timescale 1ns / 1ps
`default_nettype none

module ping_pong_sample_buffer #(
  parameter int BANK_DEPTH = ppsb_pkg::BANK_DEPTH_DEF,
  parameter int WORD_BITS  = ppsb_pkg::WORD_BITS_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire ppsb_pkg::in_item_t           in_item,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output ppsb_pkg::out_item_t               out_item,
  input  wire logic                         cfg_valid,
  output logic                              cfg_ready,
  input  wire logic [ppsb_pkg::LIMIT_W-1:0] cfg_data
);
  import ppsb_pkg::*;

  localparam int QW = $bits(ppsb_ctrl_t) + $clog2(BANK_DEPTH) + 1 + WORD_BITS;

  ppsb_q_status_t q_status;
  logic           q_push, q_pop;
  logic [QW-1:0]  q_wdata, q_rdata;

  ppsb_front #(
    .BANK_DEPTH(BANK_DEPTH),
    .WORD_BITS (WORD_BITS)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_item  (in_item),
    .in_stall (in_stall),
    .cfg_valid(cfg_valid),
    .cfg_data (cfg_data),
    .cfg_ready(cfg_ready),
    .q_status (q_status),
    .q_push   (q_push),
    .q_wdata  (q_wdata)
  );

  ppsb_queue #(
    .W    (QW),
    .DEPTH(QDEPTH)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .pop   (q_pop),
    .rdata (q_rdata),
    .status(q_status)
  );

  ppsb_back #(
    .BANK_DEPTH(BANK_DEPTH),
    .WORD_BITS (WORD_BITS)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_status (q_status),
    .q_rdata  (q_rdata),
    .q_pop    (q_pop),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_item (out_item)
  );

endmodule

`default_nettype wire

// ===== tb/sv/tb_ping_pong_sample_buffer.sv =====
// Self-checking testbench for the ping-pong sample buffer with a transaction-level predictor.
`timescale 1ns / 1ps

module tb_ping_pong_sample_buffer;
  import ppsb_pkg::*;

  localparam int BANK_DEPTH = BANK_DEPTH_DEF;
  localparam int CYCLE_LIMIT = 200000;
  localparam logic [1:0] MODE_UNUSED = 2'd3;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  in_item_t in_item;
  logic out_valid;
  logic out_stall;
  out_item_t out_item;
  logic cfg_valid;
  logic cfg_ready;
  logic [LIMIT_W-1:0] cfg_data;

  // Predicted buffer state
  logic [DATA_W-1:0] bank_words [2][BANK_DEPTH];
  logic [7:0] bank_head [2];
  logic [8:0] bank_count [2];
  logic write_sel;
  logic [LIMIT_W-1:0] push_limit;

  out_item_t expected_results [$];

  // Idling controls and run statistics
  bit in_gaps_on;
  bit out_gaps_on;
  int cycle_count;
  int mismatch_count;
  int op_count;
  int result_count;
  int refused_pushes;
  int auto_swaps;
  int limit_writes;

  ping_pong_sample_buffer dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_item(in_item),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_item(out_item),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Stop a hung run
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
             expected_results.size());
    $display("** ping_pong_sample_buffer: FAILED **");
    $finish;
  end

  // Apply one transaction to the predicted state and return its result
  function automatic out_item_t buffer_apply(in_item_t op);
    out_item_t res;
    logic wb;
    logic rb;
    logic [LIMIT_W-1:0] lim;
    int slot;
    res = '0;
    lim = (push_limit > BANK_DEPTH) ? LIMIT_W'(BANK_DEPTH) : push_limit;
    case (op.mode)
      MODE_PUSH: begin
        wb = write_sel;
        if (bank_count[wb] < lim) begin
          slot = (int'(bank_head[wb]) + int'(bank_count[wb])) % BANK_DEPTH;
          bank_words[wb][slot] = op.data_value;
          bank_count[wb] = bank_count[wb] + 9'd1;
          res.ok = 1'b1;
        end else begin
          refused_pushes++;
        end
      end
      MODE_POP: begin
        rb = ~write_sel;
        // Swap in the write bank when the read bank has run dry
        if (bank_count[rb] == 0 && bank_count[write_sel] != 0) begin
          write_sel = ~write_sel;
          auto_swaps++;
        end
        rb = ~write_sel;
        if (bank_count[rb] != 0) begin
          res.popped_value = bank_words[rb][bank_head[rb]];
          bank_head[rb] = 8'((int'(bank_head[rb]) + 1) % BANK_DEPTH);
          bank_count[rb] = bank_count[rb] - 9'd1;
          res.ok = 1'b1;
        end
      end
      MODE_SWAP: begin
        if (bank_count[write_sel] != 0) begin
          write_sel = ~write_sel;
          res.ok = 1'b1;
        end
      end
      default: ;
    endcase
    res.total_count = OUT_COUNT_W'(bank_count[0]) + OUT_COUNT_W'(bank_count[1]);
    res.is_empty = (res.total_count == 0);
    return res;
  endfunction

  task automatic report_mismatch(string what, logic [DATA_W-1:0] got,
                                 logic [DATA_W-1:0] want);
    $display("mismatch at cycle %0d: %s got %h want %h", cycle_count, what, got, want);
    mismatch_count++;
  endtask

  // Drive the result stall in random bursts
  initial begin
    int stall_left;
    stall_left = 0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_left == 0 && out_gaps_on && $urandom_range(0, 7) == 0)
        stall_left = $urandom_range(1, 10);
      if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Check each result transaction against the oldest expectation
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      result_count++;
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected result, popped_value", out_item.popped_value, '0);
      end else begin
        want = expected_results.pop_front();
        if (out_item.ok !== want.ok)
          report_mismatch("ok", DATA_W'(out_item.ok), DATA_W'(want.ok));
        if (out_item.popped_value !== want.popped_value)
          report_mismatch("popped_value", out_item.popped_value, want.popped_value);
        if (out_item.total_count !== want.total_count)
          report_mismatch("total_count", DATA_W'(out_item.total_count),
                          DATA_W'(want.total_count));
        if (out_item.is_empty !== want.is_empty)
          report_mismatch("is_empty", DATA_W'(out_item.is_empty), DATA_W'(want.is_empty));
      end
    end
  end

  function automatic logic [DATA_W-1:0] random_word();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // Hold the input channel idle, with noise on the payload
  task automatic idle_input(int cycles);
    repeat (cycles) begin
      @(negedge clk);
      in_valid <= 1'b0;
      in_item <= {2'($urandom), random_word()};
    end
  endtask

  // Offer one transaction, hold it until taken, then predict its result
  task automatic send_op(logic [1:0] mode, logic [DATA_W-1:0] value);
    in_item_t op;
    op.mode = mode;
    op.data_value = value;
    if (in_gaps_on && $urandom_range(0, 5) == 0)
      idle_input($urandom_range(1, 10));
    @(negedge clk);
    in_valid <= 1'b1;
    in_item <= op;
    do @(posedge clk); while (in_stall);
    op_count++;
    expected_results.push_back(buffer_apply(op));
  endtask

  // Pause the sender until every expected result has come back
  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_limit(logic [LIMIT_W-1:0] value);
    drain_results();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    push_limit = value;
    limit_writes++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_idling(bit on);
    in_gaps_on = on;
    out_gaps_on = on;
  endtask

  // Random mix: push_pct pushes, swap_pct swaps, 2 percent unused-mode ops, the rest pops
  task automatic run_traffic(int count, int push_pct, int swap_pct);
    int pick;
    repeat (count) begin
      pick = $urandom_range(0, 99);
      if (pick < push_pct)
        send_op(MODE_PUSH, random_word());
      else if (pick < push_pct + swap_pct)
        send_op(MODE_SWAP, random_word());
      else if (pick < push_pct + swap_pct + 2)
        send_op(MODE_UNUSED, random_word());
      else
        send_op(MODE_POP, random_word());
    end
  endtask

  // Refusals on an empty buffer and the unused mode
  task automatic test_empty_refusals();
    send_op(MODE_POP, '1);
    send_op(MODE_SWAP, '0);
    send_op(MODE_UNUSED, 64'h0123_4567_89ab_cdef);
  endtask

  // Word extremes through an explicit swap and an automatic one
  task automatic test_word_extremes();
    send_op(MODE_PUSH, '0);
    send_op(MODE_PUSH, '1);
    send_op(MODE_PUSH, 64'haaaa_aaaa_aaaa_aaaa);
    send_op(MODE_SWAP, '0);
    send_op(MODE_PUSH, 64'h5555_5555_5555_5555);
    send_op(MODE_UNUSED, '1);
    repeat (4) send_op(MODE_POP, '0);
    send_op(MODE_POP, '1);
  endtask

  // A limit of one, then a zero limit that refuses every push
  task automatic test_limit_edges();
    write_limit(9'd1);
    send_op(MODE_PUSH, 64'h8000_0000_0000_0001);
    send_op(MODE_PUSH, 64'h7fff_ffff_ffff_fffe);
    send_op(MODE_SWAP, '0);
    send_op(MODE_PUSH, 64'hdead_beef_cafe_f00d);
    send_op(MODE_PUSH, '1);
    write_limit(9'd0);
    send_op(MODE_PUSH, '1);
  endtask

  // Leftover entries swapped back into the write bank count against the limit
  task automatic test_full_after_swap();
    write_limit(9'd2);
    send_op(MODE_POP, '0);
    send_op(MODE_POP, '0);
    send_op(MODE_PUSH, 64'h1111_1111_1111_1111);
    send_op(MODE_PUSH, 64'h2222_2222_2222_2222);
    send_op(MODE_SWAP, '0);
    send_op(MODE_POP, '0);
    send_op(MODE_PUSH, 64'h3333_3333_3333_3333);
    send_op(MODE_PUSH, 64'h4444_4444_4444_4444);
    send_op(MODE_SWAP, '0);
    send_op(MODE_PUSH, 64'h5555_0000_5555_0000);
    send_op(MODE_PUSH, 64'h6666_6666_6666_6666);
    write_limit(9'd1);
    send_op(MODE_PUSH, 64'h7777_7777_7777_7777);
  endtask

  task automatic test_balanced_traffic();
    write_limit(LIMIT_RESET);
    run_traffic(300, 45, 8);
  endtask

  task automatic test_tiny_limit();
    write_limit(9'd3);
    run_traffic(200, 50, 10);
  endtask

  // Limit above the bank depth; push-heavy so a bank fills to depth
  task automatic test_fill_to_depth();
    write_limit(9'd511);
    run_traffic(200, 75, 1);
    drain_results();
    run_traffic(200, 75, 1);
  endtask

  task automatic test_random_limit_no_idle();
    set_idling(1'b0);
    write_limit(LIMIT_W'($urandom_range(1, 300)));
    run_traffic(250, 40, 6);
    set_idling(1'b1);
  endtask

  task automatic test_single_entry_limit();
    write_limit(9'd1);
    run_traffic(150, 50, 15);
  endtask

  // Drain toward empty at full rate
  task automatic test_closing_burst();
    set_idling(1'b0);
    write_limit(LIMIT_RESET);
    run_traffic(250, 30, 5);
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_item = '0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    mismatch_count = 0;
    op_count = 0;
    result_count = 0;
    refused_pushes = 0;
    auto_swaps = 0;
    limit_writes = 0;
    bank_head[0] = '0;
    bank_head[1] = '0;
    bank_count[0] = '0;
    bank_count[1] = '0;
    write_sel = 1'b0;
    push_limit = LIMIT_RESET;
    set_idling(1'b1);

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_empty_refusals();
    test_word_extremes();
    test_limit_edges();
    test_full_after_swap();
    test_balanced_traffic();
    test_tiny_limit();
    test_fill_to_depth();
    test_single_entry_limit();
    test_random_limit_no_idle();
    test_closing_burst();

    // Wait out the last results and watch for strays
    drain_results();
    repeat (10) @(posedge clk);

    $display("ran %0d transactions and checked %0d results over %0d limit writes",
             op_count, result_count, limit_writes);
    $display("saw %0d refused pushes and %0d automatic swaps, %0d mismatches",
             refused_pushes, auto_swaps, mismatch_count);
    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("** ping_pong_sample_buffer: PASSED **");
    end else begin
      $display("** ping_pong_sample_buffer: FAILED **");
    end
    $finish;
  end

endmodule
